>>> hw/rtl/ifs_pkg.sv
package ifs_pkg;

    // Result event codes.
    typedef enum logic [1:0] {
        EV_BYTE = 2'd0,
        EV_END  = 2'd1,
        EV_DONE = 2'd2
    } event_t;

    // Splitter phase, one-hot.
    typedef enum logic [2:0] {
        PH_LEAD  = 3'b001,
        PH_FIELD = 3'b010,
        PH_DELIM = 3'b100
    } phase_t;

    localparam int FIELD_NUM_W = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int MASK_WORDS  = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_MASK_0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_MASK_1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_MASK_2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_MASK_3 = 8'd3;

    // Reset delimiter set: tab, newline and space.
    localparam logic [CFG_DATA_W-1:0] DELIM_MASK_0_RST = 64'h0000_0001_0000_0600;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Result queue geometry.
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    typedef struct packed {
        event_t                 event_res;
        logic [7:0]             field_byte;
        logic [FIELD_NUM_W-1:0] field_number;
        logic                   last;
    } res_t;

    // Results produced by one accepted item, written to the queue together.
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } res_push_t;

    typedef struct packed {
        logic is_delim;
        logic is_white;
    } byte_class_t;

endpackage

>>> hw/rtl/ifs_if.sv
interface ifs_byte_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_value;

    modport source (output valid, output kind, output byte_value, input ready);
    modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

interface ifs_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [7:0]  field_byte;
    logic [15:0] field_number;
    logic        last;

    modport source (output valid, output event_res, output field_byte,
                    output field_number, output last, input ready);
    modport sink   (input valid, input event_res, input field_byte,
                    input field_number, input last, output ready);
endinterface

interface ifs_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/ifs_field_splitter_top.sv
// Streaming field splitter. Each input transfer carries either one string byte
// or an end-of-string mark; a 256-bit delimiter set held in four 64-bit
// configuration registers splits the string into fields, with space, tab and
// newline delimiters acting as collapsible whitespace. Every field byte comes
// out as a byte event, every completed field as a field-end event, and the end
// of string as a finished event that carries the (saturating) field count.
// The block takes one input transfer per cycle: the delimiter lookup and the
// phase update are a single level of logic that writes straight into a
// four-entry result queue, and the first result is visible the cycle after
// its input transfer. Input ready stays high while the queue has two free
// entries, so a stream of bytes and single results flows at one per cycle
// with the output taken every cycle; an end of string that closes an open
// field produces two results, which the output drains at one per cycle.
// The configuration port is always ready and should be written only while
// the block is idle.
module ifs_field_splitter_top #(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    ifs_byte_if.sink  byte_in,
    ifs_res_if.source result,
    ifs_cfg_if.sink   cfg
);
    import ifs_pkg::*;

    byte_class_t cls;
    res_push_t   push;
    logic        space_ok;
    logic        in_xfer;

    // Delimiter set and the per-byte class lookup.
    ifs_mask_regs u_mask (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .byte_value (byte_in.byte_value),
        .cls        (cls)
    );

    assign byte_in.ready = space_ok;
    assign in_xfer       = byte_in.valid && byte_in.ready;

    // Phase, separator flag and field count; forms the results of each transfer.
    ifs_split_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_xfer),
        .kind       (byte_in.kind),
        .byte_value (byte_in.byte_value),
        .cls        (cls),
        .push       (push)
    );

    // Result queue that decouples the output side from the input side.
    ifs_out_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space_ok (space_ok),
        .res      (result)
    );

`ifndef SYNTHESIS
    // Results are only produced by an input transfer.
    a_push_needs_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        !in_xfer |-> push.cnt == 2'd0)
        else $error("result pushed without an input transfer");

    // An end of string always ends with a finished event marked last.
    a_eos_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && byte_in.kind) |->
            ((push.cnt == 2'd1 && push.r0.event_res == EV_DONE && push.r0.last) ||
             (push.cnt == 2'd2 && push.r1.event_res == EV_DONE && push.r1.last &&
              push.r0.event_res == EV_END && !push.r0.last)))
        else $error("end of string without a finished event");

    // A string byte never yields two results.
    a_byte_single: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !byte_in.kind) |-> push.cnt != 2'd2)
        else $error("string byte produced two results");

    // A pushed field byte carries the byte just transferred.
    a_byte_value: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && push.cnt == 2'd1 && push.r0.event_res == EV_BYTE) |->
            (push.r0.field_byte == byte_in.byte_value && !byte_in.kind))
        else $error("field byte does not match the input byte");
`endif

endmodule

>>> hw/rtl/ifs_mask_regs.sv
module ifs_mask_regs
(
    input  logic                     clk,
    input  logic                     rst_n,
    ifs_cfg_if.sink                  cfg,
    input  logic [7:0]               byte_value,
    output ifs_pkg::byte_class_t     cls
);
    import ifs_pkg::*;

    logic [CFG_DATA_W-1:0] mask_reg [MASK_WORDS];
    logic                  mask_bit;
    logic                  is_ws_char;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg[0] <= DELIM_MASK_0_RST;
            mask_reg[1] <= '0;
            mask_reg[2] <= '0;
            mask_reg[3] <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DELIM_MASK_0: mask_reg[0] <= cfg.data;
                REG_DELIM_MASK_1: mask_reg[1] <= cfg.data;
                REG_DELIM_MASK_2: mask_reg[2] <= cfg.data;
                REG_DELIM_MASK_3: mask_reg[3] <= cfg.data;
                default:          ;
            endcase
        end
    end

    // Byte zero is never a delimiter.
    assign mask_bit   = mask_reg[byte_value[7:6]][byte_value[5:0]];
    assign is_ws_char = (byte_value == CH_SPACE) || (byte_value == CH_TAB) ||
                        (byte_value == CH_NL);

    assign cls.is_delim = mask_bit && (byte_value != 8'd0);
    assign cls.is_white = cls.is_delim && is_ws_char;

endmodule

>>> hw/rtl/ifs_split_core.sv
module ifs_split_core #(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   kind,
    input  logic [7:0]             byte_value,
    input  ifs_pkg::byte_class_t   cls,
    output ifs_pkg::res_push_t     push
);
    import ifs_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic                   sep_reg, sep_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [1:0]             n_res;
    res_t                   r0, r1;

    function automatic res_t mk_res(event_t ev, logic [7:0] b,
                                    logic [COUNT_WIDTH-1:0] num, logic lst);
        res_t r;
        r.event_res    = ev;
        r.field_byte   = b;
        r.field_number = FIELD_NUM_W'(num);
        r.last         = lst;
        return r;
    endfunction

    // The count saturates at all ones.
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + COUNT_WIDTH'(1);

    always_comb
    begin
        phase_next = phase_reg;
        sep_next   = sep_reg;
        count_next = count_reg;
        n_res      = 2'd0;
        r0         = mk_res(EV_END, 8'd0, count_reg, 1'b1);
        r1         = mk_res(EV_DONE, 8'd0, count_inc, 1'b1);

        if (kind)
        begin
            // End of string closes an open field, then reports the count.
            if (phase_reg == PH_FIELD)
            begin
                r0    = mk_res(EV_END, 8'd0, count_reg, 1'b0);
                n_res = 2'd2;
            end
            else
            begin
                r0    = mk_res(EV_DONE, 8'd0, count_reg, 1'b1);
                n_res = 2'd1;
            end
            phase_next = PH_LEAD;
            sep_next   = 1'b0;
            count_next = '0;
        end
        else if (!cls.is_delim)
        begin
            phase_next = PH_FIELD;
            r0         = mk_res(EV_BYTE, byte_value, count_reg, 1'b1);
            n_res      = 2'd1;
        end
        else
        begin
            unique case (phase_reg)
                PH_FIELD:
                begin
                    n_res      = 2'd1;
                    count_next = count_inc;
                    phase_next = PH_DELIM;
                    sep_next   = !cls.is_white;
                end
                PH_DELIM:
                begin
                    // A second hard separator in one run ends an empty field.
                    if (!cls.is_white)
                    begin
                        if (sep_reg)
                        begin
                            n_res      = 2'd1;
                            count_next = count_inc;
                        end
                        sep_next = 1'b1;
                    end
                end
                default:
                begin
                    if (!cls.is_white)
                    begin
                        n_res      = 2'd1;
                        count_next = count_inc;
                        phase_next = PH_DELIM;
                        sep_next   = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            sep_reg   <= 1'b0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            sep_reg   <= sep_next;
            count_reg <= count_next;
        end
    end

    assign push.cnt = accept ? n_res : 2'd0;
    assign push.r0  = r0;
    assign push.r1  = r1;

endmodule

>>> hw/rtl/ifs_out_fifo.sv
module ifs_out_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ifs_pkg::res_push_t   push,
    output logic                 space_ok,
    ifs_res_if.source            res
);
    import ifs_pkg::*;

    res_t             entry_reg [RQ_DEPTH];
    logic [RQ_AW-1:0] head_reg, head_next;
    logic [RQ_AW-1:0] tail_reg, tail_next;
    logic [RQ_AW:0]   count_reg, count_next;
    logic [RQ_AW-1:0] tail_plus1;
    logic             pop;
    res_t             head_res;

    assign tail_plus1 = tail_reg + RQ_AW'(1);
    assign pop        = res.valid && res.ready;
    assign head_next  = pop ? head_reg + RQ_AW'(1) : head_reg;
    assign tail_next  = tail_reg + RQ_AW'(push.cnt);
    assign count_next = count_reg + (RQ_AW+1)'(push.cnt) - (RQ_AW+1)'(pop);

    // Room for the two results an end of string may bring.
    assign space_ok = count_reg <= (RQ_AW+1)'(RQ_DEPTH - 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            entry_reg[tail_reg] <= push.r0;
        end
        if (push.cnt == 2'd2)
        begin
            entry_reg[tail_plus1] <= push.r1;
        end
    end

    assign head_res         = entry_reg[head_reg];
    assign res.valid        = count_reg != '0;
    assign res.event_res    = head_res.event_res;
    assign res.field_byte   = head_res.field_byte;
    assign res.field_number = head_res.field_number;
    assign res.last         = head_res.last;

endmodule

>>> tb/tb_ifs_field_splitter_top.sv
`timescale 1ns / 1ps

module tb_ifs_field_splitter_top;
    import ifs_pkg::*;

    // Width of the field counter in the block. The default width is kept, so
    // the field numbers seen here match the block as it is normally built.
    localparam int          CNT_W     = 16;
    localparam int unsigned COUNT_MAX = (32'd1 << CNT_W) - 1;

    // Values of the kind field of an input transfer.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    // The first result shows up in the cycle after its input transfer, so a few
    // cycles after the last result are enough for the block to settle.
    localparam int DRAIN_CYCLES  = 4;
    localparam int END_WAIT      = 20000;
    localparam int RAND_PHASES   = 9;
    localparam int PHASE_ITEMS   = 90;
    localparam int QUIET_PHASE   = 3;
    localparam int PRESSURE_PHASE = 7;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_ERR_LINES = 100;
    localparam int SEP_RUN       = 60;

    // One row of the directed table: either a register write or an input
    // transfer. For an input row, typed_n >= 0 means the results are typed
    // in by hand; -1 leaves them to the predictor.
    typedef struct {
        bit          is_cfg;
        logic [7:0]  idx;
        logic [63:0] data;
        logic        kind;
        logic [7:0]  b;
        int          typed_n;
        res_t        r0;
        res_t        r1;
    } stim_row_t;

    logic clk;
    logic rst_n;

    ifs_byte_if byte_if ();
    ifs_res_if  res_if ();
    ifs_cfg_if  cfg_if ();

    ifs_field_splitter_top #(
        .COUNT_WIDTH(CNT_W)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .byte_in(byte_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    // Predictor state: the delimiter set as the testbench believes it is
    // programmed, and the splitter state that the block should be in.
    logic [63:0] delim_set [MASK_WORDS];
    phase_t      split_phase;
    logic        sep_seen;
    int unsigned fields_done;

    // Results that the block still owes, oldest first.
    res_t        due_results [$];
    stim_row_t   stim_table [$];
    logic [7:0]  sep_chars [3];

    bit          idle_on  = 1'b1;
    int unsigned hold_len = 0;
    int          n_errors = 0;

    // The clock runs free from time zero.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic res_t exp_res(input event_t ev, input logic [7:0] b,
                                     input int unsigned num, input logic lst);
        res_t r;
        r.event_res    = ev;
        r.field_byte   = b;
        r.field_number = FIELD_NUM_W'(num);
        r.last         = lst;
        return r;
    endfunction

    function automatic logic byte_is_delim(input logic [7:0] b);
        // Byte zero is a plain byte whatever the mask says.
        return (b != 8'h00) && delim_set[b[7:6]][b[5:0]];
    endfunction

    function automatic void bump_count();
        if (fields_done < COUNT_MAX)
            fields_done++;
    endfunction

    // Advances the predicted splitter state by one input transfer and returns
    // the results that it should cause, in order.
    function automatic void predict_split(input logic k, input logic [7:0] b,
                                          output int n, output res_t r0, output res_t r1);
        logic dl;
        logic wh;
        dl = byte_is_delim(b);
        // Space, tab and newline only count as whitespace while they are
        // members of the delimiter set.
        wh = dl && (b == CH_SPACE || b == CH_TAB || b == CH_NL);
        n  = 0;
        r0 = '0;
        r1 = '0;
        if (k == KIND_EOS)
        begin
            // An open field is closed before the finished event.
            if (split_phase == PH_FIELD)
            begin
                r0 = exp_res(EV_END, 8'h00, fields_done, 1'b0);
                bump_count();
                n = 1;
            end
            if (n == 0)
                r0 = exp_res(EV_DONE, 8'h00, fields_done, 1'b1);
            else
                r1 = exp_res(EV_DONE, 8'h00, fields_done, 1'b1);
            n           = n + 1;
            split_phase = PH_LEAD;
            sep_seen    = 1'b0;
            fields_done = 0;
        end
        else if (!dl)
        begin
            split_phase = PH_FIELD;
            r0          = exp_res(EV_BYTE, b, fields_done, 1'b1);
            n           = 1;
        end
        else if (split_phase == PH_FIELD)
        begin
            r0 = exp_res(EV_END, 8'h00, fields_done, 1'b1);
            bump_count();
            n           = 1;
            split_phase = PH_DELIM;
            sep_seen    = !wh;
        end
        else if (split_phase == PH_DELIM)
        begin
            // A second separator in one delimiter run ends an empty field;
            // whitespace inside the run changes nothing.
            if (!wh)
            begin
                if (sep_seen)
                begin
                    r0 = exp_res(EV_END, 8'h00, fields_done, 1'b1);
                    bump_count();
                    n = 1;
                end
                sep_seen = 1'b1;
            end
        end
        else if (!wh)
        begin
            // A separator at the start of the string ends an empty field.
            r0 = exp_res(EV_END, 8'h00, fields_done, 1'b1);
            bump_count();
            n           = 1;
            split_phase = PH_DELIM;
            sep_seen    = 1'b1;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        n_errors++;
        if (n_errors <= MAX_ERR_LINES)
            $display("MISMATCH at %0t: %s: expected 0x%0h, got 0x%0h",
                     $time, what, want_v, got_v);
    endtask

    // Offers one input transfer, waits until it is accepted, and queues the
    // results that it should cause. Valid is left high so that the next call
    // can present its item without a bubble.
    task automatic issue(input logic k, input logic [7:0] b, input int typed_n = -1,
                         input res_t t0 = '0, input res_t t1 = '0);
        int   n;
        res_t p0;
        res_t p1;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        byte_if.valid      <= 1'b1;
        byte_if.kind       <= k;
        byte_if.byte_value <= b;
        @(posedge clk);
        while (!byte_if.ready)
            @(posedge clk);
        predict_split(k, b, n, p0, p1);
        if (typed_n >= 0)
        begin
            n  = typed_n;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0)
            due_results.push_back(p0);
        if (n > 1)
            due_results.push_back(p1);
    endtask

    // Stops the input stream and waits until every owed result has been
    // taken, then gives the block a few cycles to finish any silent item.
    task automatic wait_drained();
        byte_if.valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        // Writes to an index beyond the last mask word are dropped.
        if (idx <= REG_DELIM_MASK_3)
            delim_set[idx[1:0]] = val;
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void add_cfg(input logic [7:0] idx, input logic [63:0] val);
        stim_row_t row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = val;
        stim_table.push_back(row);
    endfunction

    function automatic void add_in(input logic k, input logic [7:0] b, input int n = -1,
                                   input res_t r0 = '0, input res_t r1 = '0);
        stim_row_t row;
        row         = '{default: '0};
        row.kind    = k;
        row.b       = b;
        row.typed_n = n;
        row.r0      = r0;
        row.r1      = r1;
        stim_table.push_back(row);
    endfunction

    // Random string content, weighted toward whitespace and the separators
    // of the current phase so that delimiter runs of every shape occur.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0, 1:
            begin
                case ($urandom_range(0, 2))
                    0:       return CH_SPACE;
                    1:       return CH_TAB;
                    default: return CH_NL;
                endcase
            end
            2, 3, 4: return sep_chars[$urandom_range(0, 2)];
            5:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(97, 122));
        endcase
    endfunction

    // Result side: ready drops in random bursts while idling is on, and for one
    // long stretch when a hold is requested, so the four-entry result queue fills
    // and the block has to stall its input.
    initial
    begin : result_sink
        int unsigned stall_left;
        stall_left    = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                res_if.ready <= 1'b0;
                hold_len = hold_len - 1;
            end
            else if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                res_if.ready <= 1'b0;
                stall_left = $urandom_range(1, 10) - 1;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // Every accepted result is matched against the oldest owed one. Values
    // are sampled at the edge, before the block updates them.
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (due_results.size() == 0)
                report_mismatch("result with nothing expected", 32'h0,
                                {res_if.event_res, res_if.field_byte,
                                 res_if.field_number, res_if.last});
            else
            begin
                want = due_results.pop_front();
                if (want.event_res !== res_if.event_res)
                    report_mismatch("event_res", want.event_res, res_if.event_res);
                if (want.field_byte !== res_if.field_byte)
                    report_mismatch("field_byte", want.field_byte, res_if.field_byte);
                if (want.field_number !== res_if.field_number)
                    report_mismatch("field_number", want.field_number, res_if.field_number);
                if (want.last !== res_if.last)
                    report_mismatch("last", want.last, res_if.last);
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t   row;
        int unsigned sent;
        int unsigned len;
        int unsigned guard;
        logic [63:0] sep_word;
        logic [63:0] new_set [MASK_WORDS];

        // All inputs start at known values, and reset is held low at first.
        rst_n              <= 1'b0;
        byte_if.valid      <= 1'b0;
        byte_if.kind       <= KIND_BYTE;
        byte_if.byte_value <= 8'h00;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= REG_DELIM_MASK_0;
        cfg_if.data        <= '0;

        delim_set[0] = DELIM_MASK_0_RST;
        delim_set[1] = '0;
        delim_set[2] = '0;
        delim_set[3] = '0;
        split_phase  = PH_LEAD;
        sep_seen     = 1'b0;
        fields_done  = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part, starting from the reset delimiter set. An empty
        // string gives only the finished event with a count of zero.
        add_in(KIND_EOS, 8'h00, 1, exp_res(EV_DONE, 8'h00, 0, 1'b1));
        // Leading whitespace is skipped silently.
        add_in(KIND_BYTE, CH_SPACE, 0);
        add_in(KIND_BYTE, 8'h41, 1, exp_res(EV_BYTE, 8'h41, 0, 1'b1));
        // Byte zero and the top byte value are ordinary field bytes.
        add_in(KIND_BYTE, 8'h00, 1, exp_res(EV_BYTE, 8'h00, 0, 1'b1));
        add_in(KIND_BYTE, 8'hFF, 1, exp_res(EV_BYTE, 8'hFF, 0, 1'b1));
        // Whitespace ends the field and collapses with further whitespace.
        add_in(KIND_BYTE, CH_TAB, 1, exp_res(EV_END, 8'h00, 0, 1'b1));
        add_in(KIND_BYTE, CH_NL, 0);
        add_in(KIND_BYTE, 8'h62, 1, exp_res(EV_BYTE, 8'h62, 1, 1'b1));
        // End of string inside a field closes it before finishing.
        add_in(KIND_EOS, 8'h00, 2, exp_res(EV_END, 8'h00, 1, 1'b0),
               exp_res(EV_DONE, 8'h00, 2, 1'b1));

        // A write beyond the last mask word must leave the set alone; then
        // the colon joins the whitespace as a separator.
        add_cfg(REG_DELIM_MASK_3 + 8'd1, '1);
        add_cfg(REG_DELIM_MASK_0, DELIM_MASK_0_RST | 64'h0400_0000_0000_0000);
        // A leading separator ends an empty field; a second separator in the
        // same run, with whitespace between, ends another.
        add_in(KIND_BYTE, 8'h3A, 1, exp_res(EV_END, 8'h00, 0, 1'b1));
        add_in(KIND_BYTE, CH_SPACE, 0);
        add_in(KIND_BYTE, 8'h3A, 1, exp_res(EV_END, 8'h00, 1, 1'b1));
        add_in(KIND_BYTE, 8'h78);
        add_in(KIND_BYTE, 8'h3A);
        add_in(KIND_BYTE, 8'h3A);
        // The string ends inside a delimiter run, so no field is added.
        add_in(KIND_EOS, 8'h00);

        // Every byte value is a delimiter, yet byte zero still is not.
        add_cfg(REG_DELIM_MASK_0, '1);
        add_cfg(REG_DELIM_MASK_1, '1);
        add_cfg(REG_DELIM_MASK_2, '1);
        add_cfg(REG_DELIM_MASK_3, '1);
        add_in(KIND_BYTE, 8'h00, 1, exp_res(EV_BYTE, 8'h00, 0, 1'b1));
        add_in(KIND_BYTE, 8'h80, 1, exp_res(EV_END, 8'h00, 0, 1'b1));
        add_in(KIND_BYTE, 8'hFF, 1, exp_res(EV_END, 8'h00, 1, 1'b1));
        add_in(KIND_EOS, 8'h00, 1, exp_res(EV_DONE, 8'h00, 2, 1'b1));

        // With an empty set the whole string is a single field.
        add_cfg(REG_DELIM_MASK_0, '0);
        add_cfg(REG_DELIM_MASK_1, '0);
        add_cfg(REG_DELIM_MASK_2, '0);
        add_cfg(REG_DELIM_MASK_3, '0);
        add_in(KIND_BYTE, CH_SPACE, 1, exp_res(EV_BYTE, CH_SPACE, 0, 1'b1));
        add_in(KIND_BYTE, 8'h7F, 1, exp_res(EV_BYTE, 8'h7F, 0, 1'b1));
        add_in(KIND_EOS, 8'h00, 2, exp_res(EV_END, 8'h00, 0, 1'b0),
               exp_res(EV_DONE, 8'h00, 1, 1'b1));

        foreach (stim_table[i])
        begin
            row = stim_table[i];
            if (row.is_cfg)
            begin
                wait_drained();
                write_reg(row.idx, row.data);
            end
            else
                issue(row.kind, row.b, row.typed_n, row.r0, row.r1);
        end

        // Random part. Each phase programs a new delimiter set while the
        // block is idle; a phase may stop in the middle of a string, so the
        // new set then applies from the next byte of that string.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_drained();
            for (int i = 0; i < 3; i++)
                sep_chars[i] = 8'($urandom_range(1, 255));
            for (int w = 0; w < MASK_WORDS; w++)
            begin
                sep_word = '0;
                for (int i = 0; i < 3; i++)
                    if (sep_chars[i][7:6] == w)
                        sep_word[sep_chars[i][5:0]] = 1'b1;
                case (ph % 6)
                    0:       new_set[w] = (w == 0) ? DELIM_MASK_0_RST : '0;
                    1:       new_set[w] = ((w == 0) ? DELIM_MASK_0_RST : '0) | sep_word;
                    2:       new_set[w] = '1;
                    3:       new_set[w] = '0;
                    4:       new_set[w] = {$urandom, $urandom} | sep_word;
                    default: new_set[w] = sep_word;
                endcase
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_DELIM_MASK_3 + 8'($urandom_range(1, 252)), {$urandom, $urandom});
            for (int w = 0; w < MASK_WORDS; w++)
                write_reg(REG_DELIM_MASK_0 + 8'(w), new_set[w]);

            // The quiet and pressure phases run with no idling. In the pressure phase the
            // sender keeps offering items while the result side holds off.
            idle_on = (ph != QUIET_PHASE) && (ph != PRESSURE_PHASE);
            if (ph == PRESSURE_PHASE)
                hold_len = HOLD_CYCLES;

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(0, 12);
                repeat (len)
                begin
                    issue(KIND_BYTE, pick_byte());
                    sent++;
                end
                if (sent < PHASE_ITEMS || $urandom_range(0, 2) != 0)
                begin
                    issue(KIND_EOS, 8'($urandom_range(0, 255)));
                    sent++;
                end
            end
        end

        // Last part, with no idling: a string made of separators alone ends
        // one empty field per byte, back to back. The short string after it
        // shows that the count starts again from zero.
        wait_drained();
        idle_on = 1'b0;
        write_reg(REG_DELIM_MASK_0, DELIM_MASK_0_RST | 64'h0000_1000_0000_0000);
        write_reg(REG_DELIM_MASK_1, '0);
        write_reg(REG_DELIM_MASK_2, '0);
        write_reg(REG_DELIM_MASK_3, '0);
        repeat (SEP_RUN)
            issue(KIND_BYTE, 8'h2C);
        issue(KIND_BYTE, 8'h7A);
        issue(KIND_EOS, 8'h00);
        issue(KIND_BYTE, 8'h71);
        issue(KIND_EOS, 8'h00);

        // Wind down: wait for the owed results, with a limit, then a few
        // cycles more to catch anything extra.
        byte_if.valid <= 1'b0;
        guard = 0;
        while (due_results.size() != 0 && guard < END_WAIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        if (due_results.size() != 0)
            report_mismatch("results never delivered", due_results.size(), 32'h0);

        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/ifs_pkg.sv
hw/rtl/ifs_if.sv
hw/rtl/ifs_mask_regs.sv
hw/rtl/ifs_split_core.sv
hw/rtl/ifs_out_fifo.sv
hw/rtl/ifs_field_splitter_top.sv
tb/tb_ifs_field_splitter_top.sv
